@@ rtl/vfrt_pkg.sv @@
package vfrt_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_MAX_FRAME_BYTES = 8'd0;
    localparam logic [7:0] CFG_MAX_SEQ_GAP     = 8'd1;
    localparam logic [7:0] CFG_MAX_FRAME_GAP   = 8'd2;
    localparam logic [7:0] CFG_RESTART_RUN     = 8'd3;

    localparam logic [23:0] RST_MAX_FRAME_BYTES = 24'd12441600;
    localparam logic [30:0] RST_MAX_SEQ_GAP     = 31'd1048576;
    localparam logic [30:0] RST_MAX_FRAME_GAP   = 31'd4096;
    localparam logic [3:0]  RST_RESTART_RUN     = 4'd4;

    // Commands from the tracker to the coverage engine
    typedef struct packed {
        logic start;
        logic clear;
    } cov_cmd_t;

    // Coverage engine status
    typedef struct packed {
        logic busy;
        logic done;
        logic overflow;
        logic nonempty;
    } cov_stat_t;

endpackage

@@ rtl/vfrt_in_if.sv @@
interface vfrt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] seq_number;
    logic [31:0] frame_number;
    logic        frag_start;
    logic        frag_end;
    logic [31:0] frame_bytes;
    logic [31:0] byte_offset;
    logic [31:0] declared_len;
    logic [15:0] carried_len;

    modport source (output valid, output seq_number, output frame_number,
                    output frag_start, output frag_end, output frame_bytes,
                    output byte_offset, output declared_len, output carried_len,
                    input ready);
    modport sink (input valid, input seq_number, input frame_number,
                  input frag_start, input frag_end, input frame_bytes,
                  input byte_offset, input declared_len, input carried_len,
                  output ready);
endinterface

@@ rtl/vfrt_out_if.sv @@
interface vfrt_out_if;
    logic        valid;
    logic        ready;
    logic        loss_detected;
    logic        frame_ended;
    logic        frame_complete;
    logic [31:0] frames_whole;
    logic [31:0] frames_broken;
    logic [31:0] frames_missing;
    logic [31:0] packets_missing;

    modport source (output valid, output loss_detected, output frame_ended,
                    output frame_complete, output frames_whole, output frames_broken,
                    output frames_missing, output packets_missing, input ready);
    modport sink (input valid, input loss_detected, input frame_ended,
                  input frame_complete, input frames_whole, input frames_broken,
                  input frames_missing, input packets_missing, output ready);
endinterface

@@ rtl/vfrt_cfg_if.sv @@
interface vfrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/vfrt_cover.sv @@
module vfrt_cover #(
    parameter int COVER_SLOTS = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vfrt_pkg::cov_cmd_t     cmd,
    input  logic [OFFSET_BITS-1:0] new_lo,
    input  logic [OFFSET_BITS-1:0] new_hi,
    output vfrt_pkg::cov_stat_t    stat,
    output logic [OFFSET_BITS-1:0] first_lo,
    output logic [OFFSET_BITS-1:0] first_hi
);

    localparam int AW = (COVER_SLOTS > 1) ? $clog2(COVER_SLOTS) : 1;
    localparam int CW = $clog2(COVER_SLOTS + 1);
    localparam int WW = $clog2(COVER_SLOTS + 2);
    localparam int DW = 2 * OFFSET_BITS;

    typedef enum logic [4:0] {
        C_IDLE  = 5'b00001,
        C_FETCH = 5'b00010,
        C_LOAD  = 5'b00100,
        C_MERGE = 5'b01000,
        C_FLUSH = 5'b10000
    } cov_state_t;

    // Two banks: read the current set from one, stream the merged set into the other
    logic [DW-1:0] mem0 [COVER_SLOTS];
    logic [DW-1:0] mem1 [COVER_SLOTS];
    logic [DW-1:0] rd_data_reg;

    cov_state_t             state_reg, state_next;
    logic                   bank_reg, bank_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic [OFFSET_BITS-1:0] first_lo_reg, first_lo_next, first_hi_reg, first_hi_next;
    logic [CW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [WW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [OFFSET_BITS-1:0] nlo_reg, nlo_next, nhi_reg, nhi_next;
    logic                   pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] hlo_reg, hlo_next, hhi_reg, hhi_next;
    logic                   hvld_reg, hvld_next;
    logic [OFFSET_BITS-1:0] alo_reg, alo_next, ahi_reg, ahi_next;
    logic                   avld_reg, avld_next;
    logic [OFFSET_BITS-1:0] flo_reg, flo_next, fhi_reg, fhi_next;
    logic                   done;

    logic                   emit_en;
    logic [DW-1:0]          emit_data;
    logic                   take_new;
    logic [OFFSET_BITS-1:0] elo, ehi;
    logic [WW-1:0]          wcnt;

    always_ff @(posedge clk)
    begin
        if (emit_en && (wr_ptr_reg < WW'(COVER_SLOTS)))
        begin
            if (bank_reg)
                mem0[wr_ptr_reg[AW-1:0]] <= emit_data;
            else
                mem1[wr_ptr_reg[AW-1:0]] <= emit_data;
        end
        rd_data_reg <= bank_reg ? mem1[rd_ptr_reg[AW-1:0]] : mem0[rd_ptr_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        first_lo_next = first_lo_reg;
        first_hi_next = first_hi_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        nlo_next      = nlo_reg;
        nhi_next      = nhi_reg;
        pend_next     = pend_reg;
        hlo_next      = hlo_reg;
        hhi_next      = hhi_reg;
        hvld_next     = hvld_reg;
        alo_next      = alo_reg;
        ahi_next      = ahi_reg;
        avld_next     = avld_reg;
        flo_next      = flo_reg;
        fhi_next      = fhi_reg;
        emit_en       = 1'b0;
        emit_data     = {ahi_reg, alo_reg};
        done          = 1'b0;
        take_new      = pend_reg && (!hvld_reg || (nlo_reg <= hlo_reg));
        elo           = take_new ? nlo_reg : hlo_reg;
        ehi           = take_new ? nhi_reg : hhi_reg;
        wcnt          = wr_ptr_reg + WW'(avld_reg);

        case (state_reg)
            C_IDLE:
            begin
                if (cmd.clear)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                if (cmd.start)
                begin
                    nlo_next    = new_lo;
                    nhi_next    = new_hi;
                    pend_next   = 1'b1;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    avld_next   = 1'b0;
                    hvld_next   = 1'b0;
                    state_next  = C_FETCH;
                end
            end
            C_FETCH:
            begin
                if (rd_ptr_reg < count_reg)
                    state_next = C_LOAD;
                else
                begin
                    hvld_next  = 1'b0;
                    state_next = C_MERGE;
                end
            end
            C_LOAD:
            begin
                hlo_next    = rd_data_reg[OFFSET_BITS-1:0];
                hhi_next    = rd_data_reg[DW-1:OFFSET_BITS];
                hvld_next   = 1'b1;
                rd_ptr_next = rd_ptr_reg + CW'(1);
                state_next  = C_MERGE;
            end
            C_MERGE:
            begin
                if (take_new || hvld_reg)
                begin
                    // merge into the accumulator when touching, else push it out
                    if (avld_reg && (elo <= ahi_reg))
                    begin
                        if (ehi > ahi_reg)
                            ahi_next = ehi;
                    end
                    else
                    begin
                        if (avld_reg)
                        begin
                            emit_en     = 1'b1;
                            wr_ptr_next = wr_ptr_reg + WW'(1);
                            if (wr_ptr_reg == '0)
                            begin
                                flo_next = alo_reg;
                                fhi_next = ahi_reg;
                            end
                        end
                        alo_next  = elo;
                        ahi_next  = ehi;
                        avld_next = 1'b1;
                    end
                    if (take_new)
                    begin
                        pend_next  = 1'b0;
                        state_next = hvld_reg ? C_MERGE : C_FLUSH;
                    end
                    else
                    begin
                        hvld_next  = 1'b0;
                        state_next = C_FETCH;
                    end
                end
                else
                    state_next = C_FLUSH;
            end
            C_FLUSH:
            begin
                emit_en = avld_reg;
                done    = 1'b1;
                if (wcnt > WW'(COVER_SLOTS))
                    ovf_next = 1'b1;
                else
                begin
                    bank_next  = !bank_reg;
                    count_next = CW'(wcnt);
                    if (wr_ptr_reg == '0)
                    begin
                        first_lo_next = alo_reg;
                        first_hi_next = ahi_reg;
                    end
                    else
                    begin
                        first_lo_next = flo_reg;
                        first_hi_next = fhi_reg;
                    end
                end
                state_next = C_IDLE;
            end
            default:
                state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            bank_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            hvld_reg  <= 1'b0;
            avld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            hvld_reg  <= hvld_next;
            avld_reg  <= avld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_lo_reg <= first_lo_next;
        first_hi_reg <= first_hi_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        nlo_reg      <= nlo_next;
        nhi_reg      <= nhi_next;
        hlo_reg      <= hlo_next;
        hhi_reg      <= hhi_next;
        alo_reg      <= alo_next;
        ahi_reg      <= ahi_next;
        flo_reg      <= flo_next;
        fhi_reg      <= fhi_next;
    end

    assign stat.busy     = (state_reg != C_IDLE);
    assign stat.done     = done;
    assign stat.overflow = ovf_reg;
    assign stat.nonempty = (count_reg != '0);
    assign first_lo      = first_lo_reg;
    assign first_hi      = first_hi_reg;

endmodule

@@ rtl/video_fragment_reassembly_tracker_unit.sv @@
// Steps: a word without new coverage passes through accept, header and finish; a word that
//   adds coverage also launches the coverage engine and streams the stored range set
//   through it (a fetch, a memory read and a merge step per stored range, plus the new
//   range, the last fetch and the flush) before finish.
// Throughput: one word at a time; the next is taken once the result is in the output
//   register, which may still wait on the sink.
// Reset: rst_n clears tracking state, counters and config registers to defaults at once;
//   latched data and range memories hold no reset; memories are only read below the fill count.
module video_fragment_reassembly_tracker_unit #(
    parameter int COVER_SLOTS = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    vfrt_cfg_if.sink   cfg,
    vfrt_in_if.sink    in_ch,
    vfrt_out_if.source out_ch
);

    typedef enum logic [4:0] {
        T_IDLE   = 5'b00001,
        T_HEAD   = 5'b00010,
        T_LAUNCH = 5'b00100,
        T_WAIT   = 5'b01000,
        T_FINISH = 5'b10000
    } trk_state_t;

    // Configuration registers
    logic [23:0] max_frame_bytes_reg;
    logic [30:0] max_seq_gap_reg;
    logic [30:0] max_frame_gap_reg;
    logic [3:0]  restart_run_reg;

    // Tracking state
    trk_state_t             state_reg, state_next;
    logic [31:0]            last_seq_reg, last_seq_next;
    logic                   seq_seen_reg, seq_seen_next;
    logic [31:0]            last_frame_reg, last_frame_next;
    logic                   frame_seen_reg, frame_seen_next;
    logic                   booked_reg, booked_next;
    logic [3:0]             behind_reg, behind_next;
    logic                   building_reg, building_next;
    logic [31:0]            bframe_reg, bframe_next;
    logic [OFFSET_BITS-1:0] bsize_reg, bsize_next;
    logic [31:0]            whole_cnt_reg, whole_cnt_next;
    logic [31:0]            broken_cnt_reg, broken_cnt_next;
    logic [31:0]            missing_cnt_reg, missing_cnt_next;
    logic [31:0]            packets_cnt_reg, packets_cnt_next;
    logic                   loss_reg, loss_next;
    logic [OFFSET_BITS-1:0] ins_lo_reg, ins_lo_next, ins_hi_reg, ins_hi_next;

    // Latched input word
    logic [31:0] s_seq_reg, s_fid_reg, s_fsize_reg, s_offset_reg, s_plen_reg;
    logic [15:0] s_carried_reg;
    logic        s_start_reg, s_end_reg;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        o_loss_reg, o_ended_reg, o_whole_reg;
    logic [31:0] o_whole_cnt_reg, o_broken_cnt_reg, o_missing_cnt_reg, o_packets_cnt_reg;
    logic        load_out;
    logic        ended, whole;

    vfrt_pkg::cov_cmd_t     cov_cmd;
    vfrt_pkg::cov_stat_t    cov_stat;
    logic [OFFSET_BITS-1:0] cov_first_lo, cov_first_hi;

    logic [31:0] seq_d, fid_d, bld_d, plen;
    logic [32:0] reach;
    logic        size_ok, stale, add_cover;
    logic [3:0]  behind_inc;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = (state_reg == T_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_bytes_reg <= vfrt_pkg::RST_MAX_FRAME_BYTES;
            max_seq_gap_reg     <= vfrt_pkg::RST_MAX_SEQ_GAP;
            max_frame_gap_reg   <= vfrt_pkg::RST_MAX_FRAME_GAP;
            restart_run_reg     <= vfrt_pkg::RST_RESTART_RUN;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                vfrt_pkg::CFG_MAX_FRAME_BYTES: max_frame_bytes_reg <= cfg.data[23:0];
                vfrt_pkg::CFG_MAX_SEQ_GAP:     max_seq_gap_reg     <= cfg.data[30:0];
                vfrt_pkg::CFG_MAX_FRAME_GAP:   max_frame_gap_reg   <= cfg.data[30:0];
                vfrt_pkg::CFG_RESTART_RUN:     restart_run_reg     <= cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // Hold the accepted word for the header and finish steps
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s_seq_reg     <= in_ch.seq_number;
            s_fid_reg     <= in_ch.frame_number;
            s_start_reg   <= in_ch.frag_start;
            s_end_reg     <= in_ch.frag_end;
            s_fsize_reg   <= in_ch.frame_bytes;
            s_offset_reg  <= in_ch.byte_offset;
            s_plen_reg    <= in_ch.declared_len;
            s_carried_reg <= in_ch.carried_len;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        last_seq_next    = last_seq_reg;
        seq_seen_next    = seq_seen_reg;
        last_frame_next  = last_frame_reg;
        frame_seen_next  = frame_seen_reg;
        booked_next      = booked_reg;
        behind_next      = behind_reg;
        building_next    = building_reg;
        bframe_next      = bframe_reg;
        bsize_next       = bsize_reg;
        whole_cnt_next   = whole_cnt_reg;
        broken_cnt_next  = broken_cnt_reg;
        missing_cnt_next = missing_cnt_reg;
        packets_cnt_next = packets_cnt_reg;
        loss_next        = loss_reg;
        ins_lo_next      = ins_lo_reg;
        ins_hi_next      = ins_hi_reg;
        out_valid_next   = out_valid_reg;
        cov_cmd          = '0;
        load_out         = 1'b0;

        seq_d      = s_seq_reg - last_seq_reg;
        fid_d      = s_fid_reg - last_frame_reg;
        bld_d      = s_fid_reg - bframe_reg;
        behind_inc = behind_reg + 4'd1;
        plen       = (32'(s_carried_reg) < s_plen_reg) ? 32'(s_carried_reg) : s_plen_reg;
        size_ok    = (s_fsize_reg != 32'd0) && (s_fsize_reg <= 32'(max_frame_bytes_reg))
                     && ((33'(s_fsize_reg) >> OFFSET_BITS) == 33'd0);
        stale      = building_reg && ((bld_d == 32'd0) || bld_d[31]);
        reach      = 33'(s_offset_reg) + 33'(plen);
        add_cover  = 1'b0;

        ended = s_end_reg && building_reg && (s_fid_reg == bframe_reg);
        whole = ended && cov_stat.nonempty && (cov_first_lo == '0)
                && (cov_first_hi >= bsize_reg);

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            T_IDLE:
            begin
                if (in_ch.valid)
                    state_next = T_HEAD;
            end
            T_HEAD:
            begin
                // sequence gap check
                loss_next = seq_seen_reg && (s_seq_reg != last_seq_reg + 32'd1);
                if (loss_next && (seq_d > 32'd1) && !seq_d[31]
                    && (seq_d <= 32'(max_seq_gap_reg)))
                    packets_cnt_next = packets_cnt_reg + seq_d - 32'd1;
                last_seq_next = s_seq_reg;
                seq_seen_next = 1'b1;

                // frame id tracking
                if (s_start_reg)
                begin
                    if (!frame_seen_reg)
                    begin
                        last_frame_next = s_fid_reg;
                        frame_seen_next = 1'b1;
                    end
                    else if ((fid_d != 32'd0) && !fid_d[31])
                    begin
                        if (!booked_reg)
                            broken_cnt_next = broken_cnt_reg + 32'd1;
                        if ((fid_d > 32'd1) && (fid_d <= 32'(max_frame_gap_reg)))
                            missing_cnt_next = missing_cnt_reg + fid_d - 32'd1;
                        last_frame_next = s_fid_reg;
                        booked_next     = 1'b0;
                        behind_next     = 4'd0;
                    end
                    else if (fid_d[31])
                    begin
                        behind_next = behind_inc;
                        if (behind_inc >= restart_run_reg)
                        begin
                            if (!booked_reg)
                                broken_cnt_next = broken_cnt_reg + 32'd1;
                            last_frame_next = s_fid_reg;
                            booked_next     = 1'b0;
                            behind_next     = 4'd0;
                        end
                    end
                end

                // start of reassembly: drop the old frame, clear the range set if the size is valid
                if (s_start_reg && !stale)
                begin
                    if (!size_ok)
                        building_next = 1'b0;
                    else
                    begin
                        building_next = 1'b1;
                        bframe_next   = s_fid_reg;
                        bsize_next    = s_fsize_reg[OFFSET_BITS-1:0];
                        cov_cmd.clear = 1'b1;
                    end
                end

                if (building_next && (s_fid_reg == bframe_next)
                    && (reach <= 33'(bsize_next)) && (plen != 32'd0)
                    && (cov_cmd.clear || !cov_stat.overflow))
                    add_cover = 1'b1;

                ins_lo_next = s_offset_reg[OFFSET_BITS-1:0];
                ins_hi_next = reach[OFFSET_BITS-1:0];
                state_next  = add_cover ? T_LAUNCH : T_FINISH;
            end
            T_LAUNCH:
            begin
                cov_cmd.start = 1'b1;
                state_next    = T_WAIT;
            end
            T_WAIT:
            begin
                if (cov_stat.done)
                    state_next = T_FINISH;
            end
            T_FINISH:
            begin
                // hold here until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out = 1'b1;
                    if (ended)
                    begin
                        if ((s_fid_reg == last_frame_reg) && !booked_reg)
                        begin
                            booked_next = 1'b1;
                            if (whole)
                                whole_cnt_next = whole_cnt_reg + 32'd1;
                            else
                                broken_cnt_next = broken_cnt_reg + 32'd1;
                        end
                        building_next = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            last_seq_reg    <= '0;
            seq_seen_reg    <= 1'b0;
            last_frame_reg  <= '0;
            frame_seen_reg  <= 1'b0;
            booked_reg      <= 1'b0;
            behind_reg      <= '0;
            building_reg    <= 1'b0;
            bframe_reg      <= '0;
            bsize_reg       <= '0;
            whole_cnt_reg   <= '0;
            broken_cnt_reg  <= '0;
            missing_cnt_reg <= '0;
            packets_cnt_reg <= '0;
            loss_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_seq_reg    <= last_seq_next;
            seq_seen_reg    <= seq_seen_next;
            last_frame_reg  <= last_frame_next;
            frame_seen_reg  <= frame_seen_next;
            booked_reg      <= booked_next;
            behind_reg      <= behind_next;
            building_reg    <= building_next;
            bframe_reg      <= bframe_next;
            bsize_reg       <= bsize_next;
            whole_cnt_reg   <= whole_cnt_next;
            broken_cnt_reg  <= broken_cnt_next;
            missing_cnt_reg <= missing_cnt_next;
            packets_cnt_reg <= packets_cnt_next;
            loss_reg        <= loss_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_lo_reg <= ins_lo_next;
        ins_hi_reg <= ins_hi_next;
        if (load_out)
        begin
            o_loss_reg        <= loss_reg;
            o_ended_reg       <= ended;
            o_whole_reg       <= whole;
            o_whole_cnt_reg   <= whole_cnt_next;
            o_broken_cnt_reg  <= broken_cnt_next;
            o_missing_cnt_reg <= missing_cnt_next;
            o_packets_cnt_reg <= packets_cnt_next;
        end
    end

    vfrt_cover #(
        .COVER_SLOTS (COVER_SLOTS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_cover (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cov_cmd),
        .new_lo   (ins_lo_reg),
        .new_hi   (ins_hi_reg),
        .stat     (cov_stat),
        .first_lo (cov_first_lo),
        .first_hi (cov_first_hi)
    );

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.loss_detected   = o_loss_reg;
    assign out_ch.frame_ended     = o_ended_reg;
    assign out_ch.frame_complete  = o_whole_reg;
    assign out_ch.frames_whole    = o_whole_cnt_reg;
    assign out_ch.frames_broken   = o_broken_cnt_reg;
    assign out_ch.frames_missing  = o_missing_cnt_reg;
    assign out_ch.packets_missing = o_packets_cnt_reg;

    // The engine only runs while the tracker waits on it
    a_engine_owned: assert property (@(posedge clk) disable iff (!rst_n)
        cov_stat.busy |-> (state_reg == T_WAIT))
        else $error("coverage engine busy outside wait state");

    // Completion is only signaled while the tracker waits on it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cov_stat.done |-> (state_reg == T_WAIT))
        else $error("coverage engine done without a pending insert");

    // A finished word always lands in the output register
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result lost at finish");

    // A complete frame is always an ended frame
    a_whole_ended: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_complete |-> out_ch.frame_ended)
        else $error("complete frame reported without end");

endmodule
